// File: design/wsd_pkg.sv
package wsd_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_B0   = 3'd0,
      PH_B1   = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   // result kinds
   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // header byte fields and length codes
   localparam logic [6:0] LEN16_CODE     = 7'd126;
   localparam logic [6:0] LEN64_CODE     = 7'd127;
   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] EXT64_BYTES    = 4'd8;
   localparam logic [3:0] KEY_BYTES      = 4'd4;
   localparam logic [3:0] HDR_BASE_LEN   = 4'd2;
   localparam logic [3:0] HDR_LEN16      = 4'd4;
   localparam logic [3:0] HDR_LEN64      = 4'd10;

   // queue between parser and output stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one classified word on its way to the output stage
   typedef struct packed {
      logic        kind;
      logic        fin;
      logic [3:0]  frame_opcode;
      logic        masked;
      logic [63:0] payload_length;
      logic [31:0] mask_key;
      logic [3:0]  header_length;
      logic [7:0]  raw_byte;
      logic [7:0]  key_byte;
      logic        last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_head_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: design/wsd_if.sv
interface wsd_req_if;
   import wsd_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_rsp_if;
   import wsd_pkg::*;

   logic        valid;
   logic        ready;
   logic        kind;
   logic        fin;
   logic [3:0]  frame_opcode;
   logic        masked;
   logic [63:0] payload_length;
   logic [31:0] mask_key;
   logic [3:0]  header_length;
   logic [7:0]  data_byte;
   logic        last;

   modport source (
      output valid, output kind, output fin, output frame_opcode, output masked,
      output payload_length, output mask_key, output header_length,
      output data_byte, output last, input ready
   );
   modport sink (
      input valid, input kind, input fin, input frame_opcode, input masked,
      input payload_length, input mask_key, input header_length,
      input data_byte, input last, output ready
   );
endinterface

// File: design/wsd_front.sv
module wsd_front (
   input  logic                  clock,
   input  logic                  reset,
   wsd_req_if.sink               req_chan,
   input  wsd_pkg::q_status_type q_status,
   output wsd_pkg::q_push_type   q_push
);
   import wsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  ext_count_ff, ext_count_in;
   logic [63:0] length_ff, length_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  key_index_ff, key_index_in;
   logic        fin_ff, fin_in;
   logic        masked_ff, masked_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [3:0]  hdr_len_ff, hdr_len_in;

   logic        accept;
   logic [7:0]  b;
   logic        len_done;
   logic        emit;
   logic        empty_frame;
   logic [7:0]  key_byte;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.in_byte;

   // key byte for the current payload position, first key byte first
   always_comb begin
      case (key_index_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // header parse and payload classification
   always_comb begin
      phase_in     = phase_ff;
      ext_count_in = ext_count_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      key_index_in = key_index_ff;
      fin_in       = fin_ff;
      masked_in    = masked_ff;
      opcode_in    = opcode_ff;
      hdr_len_in   = hdr_len_ff;
      len_done     = 1'b0;
      emit         = 1'b0;
      empty_frame  = 1'b0;
      q_push       = '0;

      if (accept) begin
         unique case (phase_ff)
            PH_B1: begin
               masked_in = masked_ff | b[7];
               if (b[6:0] == LEN16_CODE) begin
                  ext_count_in = EXT16_BYTES;
                  hdr_len_in   = HDR_LEN16;
                  phase_in     = PH_EXT;
               end else if (b[6:0] == LEN64_CODE) begin
                  ext_count_in = EXT64_BYTES;
                  hdr_len_in   = HDR_LEN64;
                  phase_in     = PH_EXT;
               end else begin
                  length_in = {57'd0, b[6:0]};
                  len_done  = 1'b1;
               end
            end
            PH_EXT: begin
               length_in    = {length_ff[55:0], b};
               ext_count_in = ext_count_ff - 4'd1;
               len_done     = (ext_count_in == 4'd0);
            end
            PH_KEY: begin
               key_in       = {key_ff[23:0], b};
               ext_count_in = ext_count_ff - 4'd1;
               emit         = (ext_count_in == 4'd0);
            end
            PH_DATA: begin
               remaining_in = remaining_ff - 64'd1;
               key_index_in = key_index_ff + 2'd1;
               if (remaining_ff == 64'd1) begin
                  phase_in = PH_B0;
               end
               q_push.valid                = 1'b1;
               q_push.entry.kind           = KIND_PAYLOAD;
               q_push.entry.raw_byte       = b;
               q_push.entry.key_byte       = key_byte;
               q_push.entry.last           = (remaining_ff == 64'd1);
            end
            default: begin
               fin_in       = b[7];
               opcode_in    = b[3:0];
               masked_in    = 1'b0;
               hdr_len_in   = HDR_BASE_LEN;
               length_in    = '0;
               key_in       = '0;
               ext_count_in = '0;
               phase_in     = PH_B1;
            end
         endcase

         // length complete: key next or header done
         if (len_done) begin
            if (masked_in) begin
               ext_count_in = KEY_BYTES;
               hdr_len_in   = hdr_len_in + KEY_BYTES;
               phase_in     = PH_KEY;
            end else begin
               emit = 1'b1;
            end
         end

         // header complete result
         if (emit) begin
            empty_frame          = (length_in == 64'd0);
            remaining_in         = length_in;
            key_index_in         = 2'd0;
            phase_in             = empty_frame ? PH_B0 : PH_DATA;
            q_push.valid         = 1'b1;
            q_push.entry.kind    = KIND_HEADER;
            q_push.entry.last    = empty_frame;
         end

         q_push.entry.fin            = fin_in;
         q_push.entry.frame_opcode   = opcode_in;
         q_push.entry.masked         = masked_in;
         q_push.entry.payload_length = length_in;
         q_push.entry.mask_key       = key_in;
         q_push.entry.header_length  = hdr_len_in;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_B0;
         ext_count_ff <= '0;
         length_ff    <= '0;
         remaining_ff <= '0;
         key_ff       <= '0;
         key_index_ff <= '0;
         fin_ff       <= 1'b0;
         masked_ff    <= 1'b0;
         opcode_ff    <= '0;
         hdr_len_ff   <= HDR_BASE_LEN;
      end else begin
         phase_ff     <= phase_in;
         ext_count_ff <= ext_count_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
         key_index_ff <= key_index_in;
         fin_ff       <= fin_in;
         masked_ff    <= masked_in;
         opcode_ff    <= opcode_in;
         hdr_len_ff   <= hdr_len_in;
      end
   end

   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      q_push.valid |-> accept)
      else $error("word queued without an accepted byte");

   a_last_payload_ends_frame: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_DATA && remaining_ff == 64'd1 |=> phase_ff == PH_B0)
      else $error("frame did not end after its last payload byte");

   a_data_has_bytes_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> remaining_ff != 64'd0)
      else $error("payload phase with no bytes left");

endmodule

// File: design/wsd_queue.sv
module wsd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  wsd_pkg::q_push_type   q_push,
   input  logic                  q_pop,
   output wsd_pkg::q_head_type   q_head,
   output wsd_pkg::q_status_type q_status
);
   import wsd_pkg::*;

   entry_type               slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign q_head.valid   = !q_status.empty;
   assign q_head.entry   = slots_ff[rd_ptr_ff];

   assign do_push = q_push.valid && !q_status.full;
   assign do_pop  = q_pop && !q_status.empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push.valid)
      else $error("word offered to a full queue");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

endmodule

// File: design/wsd_back.sv
module wsd_back (
   input  logic                clock,
   input  logic                reset,
   input  wsd_pkg::q_head_type q_head,
   output logic                q_pop,
   wsd_rsp_if.source           rsp_chan
);
   import wsd_pkg::*;

   logic        valid_ff, valid_in;
   logic        kind_ff;
   logic        fin_ff;
   logic [3:0]  opcode_ff;
   logic        masked_ff;
   logic [63:0] length_ff;
   logic [31:0] key_ff;
   logic [3:0]  hdr_len_ff;
   logic [7:0]  data_ff, data_in;
   logic        last_ff;
   logic        load;

   // output register takes a word when empty or being drained
   assign load     = q_head.valid && (!valid_ff || rsp_chan.ready);
   assign q_pop    = load;
   assign data_in  = q_head.entry.raw_byte ^ q_head.entry.key_byte;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= q_head.entry.kind;
         fin_ff     <= q_head.entry.fin;
         opcode_ff  <= q_head.entry.frame_opcode;
         masked_ff  <= q_head.entry.masked;
         length_ff  <= q_head.entry.payload_length;
         key_ff     <= q_head.entry.mask_key;
         hdr_len_ff <= q_head.entry.header_length;
         data_ff    <= data_in;
         last_ff    <= q_head.entry.last;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.kind           = kind_ff;
   assign rsp_chan.fin            = fin_ff;
   assign rsp_chan.frame_opcode   = opcode_ff;
   assign rsp_chan.masked         = masked_ff;
   assign rsp_chan.payload_length = length_ff;
   assign rsp_chan.mask_key       = key_ff;
   assign rsp_chan.header_length  = hdr_len_ff;
   assign rsp_chan.data_byte      = data_ff;
   assign rsp_chan.last           = last_ff;

   a_pop_only_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("pop from an empty queue");

endmodule

// File: design/websocket_frame_deframer.sv
// websocket frame deframer
// req_chan carries the raw framed byte stream, one byte per word. For every
// frame the block parses the header (fin, opcode, mask bit, 7/16/64-bit
// length, optional 4-byte key) and sends one header word on rsp_chan when
// the header is complete, then one word per payload byte with the byte
// unmasked. Header bytes other than the completing one give no word. The
// final payload word, or the header word of an empty frame, has last set.
// Every word repeats the header fields of its frame.
// Throughput: one byte per cycle in steady state while the queue is not
// full, with no bubbles between frames; the parser takes one byte per
// clock and the output register drains one word per clock while
// rsp_chan.ready is high. Path: the parser writes each word into a 4-word
// queue, and the output register takes it from the queue when it is empty
// or being drained.
// Stall: when rsp_chan.ready is low the output register holds its word and
// the queue fills; req_chan.ready drops once the queue holds 4 words.
// Reset (synchronous): the parser expects the first header byte of a new
// frame, the queue is emptied and rsp_chan.valid goes low.
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   wsd_req_if.sink    req_chan,
   wsd_rsp_if.source  rsp_chan
);
   import wsd_pkg::*;

   q_push_type   q_push;
   q_head_type   q_head;
   q_status_type q_status;
   logic         q_pop;

   wsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .q_push   (q_push)
   );

   wsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_head   (q_head),
      .q_status (q_status)
   );

   wsd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wsd_pkg::*;

   // one word on the result channel
   typedef struct packed {
      logic        kind;
      logic        fin;
      logic [3:0]  frame_opcode;
      logic        masked;
      logic [63:0] payload_length;
      logic [31:0] mask_key;
      logic [3:0]  header_length;
      logic [7:0]  data_byte;
      logic        last;
   } frame_word_type;

   // how the payload length is coded in the header
   typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_type;

   // frame parser mirror plus the queue of words it predicts
   class deframer_scoreboard;
      phase_type      phase;
      logic [3:0]     ext_left;
      logic [63:0]    frame_len;
      logic [63:0]    bytes_left;
      logic [31:0]    key;
      logic [1:0]     key_pos;
      logic           fin_bit;
      logic           mask_bit;
      logic [3:0]     opcode;
      logic [3:0]     hdr_bytes;
      frame_word_type pending_words[$];
      int             fail_count;
      int             word_count;

      function new();
         phase = PH_B0;
         ext_left = '0;
         frame_len = '0;
         bytes_left = '0;
         key = '0;
         key_pos = '0;
         fin_bit = 1'b0;
         mask_bit = 1'b0;
         opcode = '0;
         hdr_bytes = HDR_BASE_LEN;
         fail_count = 0;
         word_count = 0;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function void push_word(logic kind, logic [7:0] data, logic last);
         frame_word_type w;
         w.kind = kind;
         w.fin = fin_bit;
         w.frame_opcode = opcode;
         w.masked = mask_bit;
         w.payload_length = frame_len;
         w.mask_key = key;
         w.header_length = hdr_bytes;
         w.data_byte = data;
         w.last = last;
         pending_words.push_back(w);
      endfunction

      // header done: start the payload, or close an empty frame right away
      function void header_complete();
         bytes_left = frame_len;
         key_pos = '0;
         phase = (frame_len == 0) ? PH_B0 : PH_DATA;
         push_word(KIND_HEADER, 8'h00, frame_len == 0);
      endfunction

      // length done: the key follows when the mask bit is set
      function void length_complete();
         if (mask_bit) begin
            ext_left = KEY_BYTES;
            hdr_bytes = hdr_bytes + KEY_BYTES;
            phase = PH_KEY;
         end else begin
            header_complete();
         end
      endfunction

      // one accepted stream byte
      function void parse_byte(logic [7:0] b);
         logic [7:0] key_byte;
         case (phase)
            PH_B1: begin
               mask_bit = b[7];
               if (b[6:0] == LEN16_CODE) begin
                  ext_left = EXT16_BYTES;
                  hdr_bytes = HDR_LEN16;
                  phase = PH_EXT;
               end else if (b[6:0] == LEN64_CODE) begin
                  ext_left = EXT64_BYTES;
                  hdr_bytes = HDR_LEN64;
                  phase = PH_EXT;
               end else begin
                  frame_len = {57'd0, b[6:0]};
                  length_complete();
               end
            end
            PH_EXT: begin
               frame_len = {frame_len[55:0], b};
               ext_left = ext_left - 1'b1;
               if (ext_left == 0) length_complete();
            end
            PH_KEY: begin
               key = {key[23:0], b};
               ext_left = ext_left - 1'b1;
               if (ext_left == 0) header_complete();
            end
            PH_DATA: begin
               key_byte = key[8*(3 - int'(key_pos)) +: 8];
               bytes_left = bytes_left - 1'b1;
               key_pos = key_pos + 1'b1;
               if (bytes_left == 0) phase = PH_B0;
               push_word(KIND_PAYLOAD, b ^ key_byte, bytes_left == 0);
            end
            default: begin
               fin_bit = b[7];
               opcode = b[3:0];
               mask_bit = 1'b0;
               hdr_bytes = HDR_BASE_LEN;
               frame_len = '0;
               key = '0;
               ext_left = '0;
               phase = PH_B1;
            end
         endcase
      endfunction

      function string word_text(frame_word_type w);
         return $sformatf({"kind=%0d fin=%0d op=%h mask=%0d len=%h key=%h",
                           " hlen=%0d data=%h last=%0d"},
                          w.kind, w.fin, w.frame_opcode, w.masked, w.payload_length,
                          w.mask_key, w.header_length, w.data_byte, w.last);
      endfunction

      // compare one received word with the oldest prediction
      function void check_word(frame_word_type got);
         frame_word_type want;
         string bad;
         word_count++;
         if (pending_words.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("word %0d not predicted: %s", word_count, word_text(got));
            return;
         end
         want = pending_words.pop_front();
         bad = "";
         if (got.kind !== want.kind) bad = {bad, " kind"};
         if (got.fin !== want.fin) bad = {bad, " fin"};
         if (got.frame_opcode !== want.frame_opcode) bad = {bad, " frame_opcode"};
         if (got.masked !== want.masked) bad = {bad, " masked"};
         if (got.payload_length !== want.payload_length) bad = {bad, " payload_length"};
         if (got.mask_key !== want.mask_key) bad = {bad, " mask_key"};
         if (got.header_length !== want.header_length) bad = {bad, " header_length"};
         if (got.data_byte !== want.data_byte) bad = {bad, " data_byte"};
         if (got.last !== want.last) bad = {bad, " last"};
         if (bad != "") begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("word %0d mismatch in%s", word_count, bad);
               $display("  expected %s", word_text(want));
               $display("  actual   %s", word_text(got));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rx_ready = 1'b0;
   logic hold_off = 1'b0;
   logic tx_calm = 1'b0;
   logic rx_calm = 1'b0;
   int   accepted_bytes = 0;

   deframer_scoreboard sb;

   wsd_req_if req_chan();
   wsd_rsp_if rsp_chan();

   assign rsp_chan.ready = rx_ready & ~hold_off;

   websocket_frame_deframer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // offer one byte, entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 63) == 0) tx_calm = ~tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      sb.parse_byte(b);
      accepted_bytes++;
      @(negedge clock);
   endtask

   // whole frame: header, extended length, key, then payload_bytes of payload
   task automatic send_frame(input logic [7:0] b0, input logic mask_on,
                             input len_form_type form,
                             input logic [63:0] length, input logic [31:0] key,
                             input int payload_bytes);
      send_byte(b0);
      case (form)
         LEN_SHORT: send_byte({mask_on, length[6:0]});
         LEN_16: begin
            send_byte({mask_on, LEN16_CODE});
            send_byte(length[15:8]);
            send_byte(length[7:0]);
         end
         default: begin
            send_byte({mask_on, LEN64_CODE});
            for (int i = 7; i >= 0; i--) send_byte(length[8*i +: 8]);
         end
      endcase
      if (mask_on)
         for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
      repeat (payload_bytes) send_byte(8'($urandom_range(0, 255)));
   endtask

   // sender and end of run
   initial begin
      int sel;
      int len;
      logic mask_on;
      len_form_type form;
      sb = new();
      req_chan.valid = 1'b0;
      req_chan.in_byte = 8'h00;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed frames: empty unmasked, all-ones key, short 16-bit length,
      // empty masked frame
      send_frame(8'h89, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
      send_frame(8'h7f, 1'b1, LEN_SHORT, 64'd2, 32'hffff_ffff, 2);
      send_frame(8'h82, 1'b0, LEN_16, 64'd1, 32'h0, 1);
      send_frame(8'h88, 1'b1, LEN_SHORT, 64'd0, 32'h0123_4567, 0);

      // random well-formed frames with random content
      while (accepted_bytes < 1700) begin
         sel = $urandom_range(0, 99);
         mask_on = ($urandom_range(0, 2) != 0);
         if (sel < 60) begin
            form = LEN_SHORT;
            len = $urandom_range(0, 12);
         end else if (sel < 72) begin
            form = LEN_SHORT;
            len = $urandom_range(0, 125);
         end else if (sel < 88) begin
            form = LEN_16;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
         end else begin
            form = LEN_64;
            len = $urandom_range(0, 20);
         end
         send_frame(8'($urandom_range(0, 255)), mask_on, form, 64'(len), $urandom, len);
      end

      // huge 64-bit length with the top bit set, only partly sent
      send_frame(8'h82, 1'b1, LEN_64, 64'hf123_4567_89ab_cdef, $urandom, 9);

      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.fail_count == 0)
         $display("PASS websocket_frame_deframer");
      else
         $display("FAIL websocket_frame_deframer");
      $finish;
   end

   // receiver with random stalls per word
   initial begin
      int stall;
      frame_word_type got;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) rx_calm = ~rx_calm;
         stall = rx_calm ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rx_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rx_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         got.kind = rsp_chan.kind;
         got.fin = rsp_chan.fin;
         got.frame_opcode = rsp_chan.frame_opcode;
         got.masked = rsp_chan.masked;
         got.payload_length = rsp_chan.payload_length;
         got.mask_key = rsp_chan.mask_key;
         got.header_length = rsp_chan.header_length;
         got.data_byte = rsp_chan.data_byte;
         got.last = rsp_chan.last;
         sb.check_word(got);
         @(negedge clock);
      end
   end

   // long receiver hold-offs so the queue fills and input backs up
   initial begin
      int hold_points[2];
      hold_points = '{300, 1100};
      foreach (hold_points[k]) begin
         wait (accepted_bytes >= hold_points[k]);
         @(negedge clock);
         hold_off <= 1'b1;
         repeat (150) @(negedge clock);
         hold_off <= 1'b0;
      end
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("FAIL websocket_frame_deframer");
      $finish;
   end

endmodule

// File: sim.f
design/wsd_pkg.sv
design/wsd_if.sv
design/wsd_front.sv
design/wsd_queue.sv
design/wsd_back.sv
design/websocket_frame_deframer.sv
tb/sv/tb.sv
